### design/backfill_byte_credit_gate_defines.svh
// ----------------------------------------------------------------------------
// backfill byte credit gate assertion macros
// concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef BACKFILL_BYTE_CREDIT_GATE_DEFINES_SVH
`define BACKFILL_BYTE_CREDIT_GATE_DEFINES_SVH

`ifndef SYNTHESIS

`define BBCG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bbcg assertion failed");

`define BBCG_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bbcg reset assertion failed");

`else

`define BBCG_ASSERT(lbl, prop)

`define BBCG_ASSERT_RST(lbl, prop)

`endif

`endif

### design/bbcg_pkg.sv
// ----------------------------------------------------------------------------
// bbcg_pkg
// shared widths, codes, reset values and types of the byte credit gate
// ----------------------------------------------------------------------------
package bbcg_pkg;

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ       = 2'd0,
    CMD_SENT       = 2'd1,
    CMD_SCAN_RESET = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_BYTE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ITEM_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTE_LIMIT = 2'd2;

  localparam logic [BYTE_W-1:0] RST_SCAN_BYTE_LIMIT   = 32'd4194304;
  localparam logic [BYTE_W-1:0] RST_SCAN_ITEM_LIMIT   = 32'd4096;
  localparam logic [BYTE_W-1:0] RST_BUFFER_BYTE_LIMIT = 32'd20971520;

  typedef struct packed {
    logic [BYTE_W-1:0] scan_byte_limit;
    logic [BYTE_W-1:0] scan_item_limit;
    logic [BYTE_W-1:0] buffer_byte_limit;
  } limits_t;

  typedef struct packed {
    logic              valid;
    cmd_t              command;
    logic [BYTE_W-1:0] byte_count;
  } step_t;

  typedef struct packed {
    logic              accepted;
    logic              sent_error;
    logic              buffer_full;
    logic              wake_task;
    logic [BYTE_W-1:0] buffer_level;
  } result_t;

endpackage

### design/bbcg_if.sv
// ----------------------------------------------------------------------------
// bbcg channel interfaces
// valid/ready channels for request words and result words
// ----------------------------------------------------------------------------
interface bbcg_in_if;
  logic                        valid;
  logic                        ready;
  logic [bbcg_pkg::CMD_W-1:0]  command;
  logic [bbcg_pkg::BYTE_W-1:0] byte_count;

  modport source (output valid, output command, output byte_count, input ready);
  modport sink   (input valid, input command, input byte_count, output ready);
endinterface

interface bbcg_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        sent_error;
  logic                        buffer_full;
  logic                        wake_task;
  logic [bbcg_pkg::BYTE_W-1:0] buffer_level;

  modport source (output valid, output accepted, output sent_error, output buffer_full,
                  output wake_task, output buffer_level, input ready);
  modport sink   (input valid, input accepted, input sent_error, input buffer_full,
                  input wake_task, input buffer_level, output ready);
endinterface

### design/backfill_byte_credit_gate.sv
// a request word is registered in the input stage, and its result word in the result register
// throughput: one word per cycle unless stalled, set by the single input stage and result register
// a stalled result register holds the input stage; both drain at one word per cycle
// reset: synchronous active-low rst_n clears credit state, full flag and valids
// reset: limits return to 4194304 scan bytes, 4096 scan items, 20971520 buffer bytes
// ----------------------------------------------------------------------------
// backfill_byte_credit_gate
// byte credit gate for a read-ahead buffer, with limit registers and handshakes
// ----------------------------------------------------------------------------
module backfill_byte_credit_gate (
  input  logic                           clk,
  input  logic                           rst_n,
  bbcg_in_if.sink                        in_ch,
  bbcg_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [bbcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbcg_pkg::BYTE_W-1:0]    cfg_wdata
);
  import bbcg_pkg::*;

  limits_t           limits_r;
  logic              in_valid_r;
  cmd_t              in_cmd_r;
  logic [BYTE_W-1:0] in_count_r;
  logic              out_valid_r;
  result_t           out_r;
  logic              advance;
  step_t             step;
  result_t           result;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !in_valid_r || advance;

  assign step.valid      = in_valid_r && advance;
  assign step.command    = in_cmd_r;
  assign step.byte_count = in_count_r;

  bbcg_credit u_credit (
    .clk    (clk),
    .rst_n  (rst_n),
    .limits (limits_r),
    .step   (step),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.scan_byte_limit   <= RST_SCAN_BYTE_LIMIT;
      limits_r.scan_item_limit   <= RST_SCAN_ITEM_LIMIT;
      limits_r.buffer_byte_limit <= RST_BUFFER_BYTE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCAN_BYTE_LIMIT:   limits_r.scan_byte_limit   <= cfg_wdata;
        CFG_SCAN_ITEM_LIMIT:   limits_r.scan_item_limit   <= cfg_wdata;
        CFG_BUFFER_BYTE_LIMIT: limits_r.buffer_byte_limit <= cfg_wdata;
        default: begin
          limits_r <= limits_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_cmd_r   <= cmd_t'(in_ch.command);
      in_count_r <= in_ch.byte_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid) begin
      out_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = out_r.accepted;
  assign out_ch.sent_error   = out_r.sent_error;
  assign out_ch.buffer_full  = out_r.buffer_full;
  assign out_ch.wake_task    = out_r.wake_task;
  assign out_ch.buffer_level = out_r.buffer_level;

endmodule

### design/bbcg_credit.sv
// ----------------------------------------------------------------------------
// bbcg_credit
// credit state and the single pass admit / free / scan reset logic
// ----------------------------------------------------------------------------
`include "backfill_byte_credit_gate_defines.svh"

module bbcg_credit (
  input  logic              clk,
  input  logic              rst_n,
  input  bbcg_pkg::limits_t limits,
  input  bbcg_pkg::step_t   step,
  output bbcg_pkg::result_t result
);
  import bbcg_pkg::*;

  logic [BYTE_W-1:0] scan_bytes_r, scan_bytes_nxt;
  logic [BYTE_W-1:0] scan_items_r, scan_items_nxt;
  logic [BYTE_W-1:0] held_bytes_r, held_bytes_nxt;
  logic              full_r, full_nxt;
  logic [BYTE_W-1:0] pending_r, pending_nxt;

  logic [BYTE_W:0]   scan_sum;
  logic [BYTE_W:0]   held_sum;
  logic [BYTE_W+1:0] lim_x3;
  logic [BYTE_W-1:0] three_quarter;
  logic [BYTE_W-1:0] held_sub;
  logic [BYTE_W-1:0] headroom;
  logic              fits;
  logic              cleared;
  logic              acc;
  logic              err;
  logic              wake;

  assign scan_sum      = {1'b0, scan_bytes_r} + {1'b0, step.byte_count};
  assign held_sum      = {1'b0, held_bytes_r} + {1'b0, step.byte_count};
  assign lim_x3        = {1'b0, limits.buffer_byte_limit, 1'b0}
                       + {2'b00, limits.buffer_byte_limit};
  assign three_quarter = lim_x3[BYTE_W+1:2];
  assign held_sub      = held_bytes_r - step.byte_count;
  assign headroom      = limits.buffer_byte_limit - held_sub;
  assign fits          = (held_sub <= limits.buffer_byte_limit) && (headroom >= pending_r);
  assign cleared       = held_sub < three_quarter;

  always_comb begin
    scan_bytes_nxt = scan_bytes_r;
    scan_items_nxt = scan_items_r;
    held_bytes_nxt = held_bytes_r;
    full_nxt       = full_r;
    pending_nxt    = pending_r;
    acc            = 1'b0;
    err            = 1'b0;
    wake           = 1'b0;
    case (step.command)
      CMD_READ: begin
        if (scan_items_r >= limits.scan_item_limit) begin
          acc = 1'b0;
        end else if (!(scan_sum <= {1'b0, limits.scan_byte_limit}
                       || scan_bytes_r == '0)) begin
          acc = 1'b0;
        end else if (!(held_bytes_r == '0
                       || held_sum <= {1'b0, limits.buffer_byte_limit})) begin
          full_nxt    = 1'b1;
          pending_nxt = step.byte_count;
        end else begin
          acc            = 1'b1;
          scan_bytes_nxt = scan_sum[BYTE_W-1:0];
          held_bytes_nxt = held_sum[BYTE_W-1:0];
          scan_items_nxt = scan_items_r + 1'b1;
        end
      end
      CMD_SENT: begin
        if (step.byte_count > held_bytes_r) begin
          err = 1'b1;
        end else begin
          held_bytes_nxt = held_sub;
          if (full_r && fits && cleared) begin
            pending_nxt = '0;
            full_nxt    = 1'b0;
            wake        = 1'b1;
          end
        end
      end
      CMD_SCAN_RESET: begin
        scan_bytes_nxt = '0;
        scan_items_nxt = '0;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  assign result.accepted     = acc;
  assign result.sent_error   = err;
  assign result.buffer_full  = full_nxt;
  assign result.wake_task    = wake;
  assign result.buffer_level = held_bytes_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_bytes_r <= '0;
      scan_items_r <= '0;
      held_bytes_r <= '0;
      full_r       <= 1'b0;
      pending_r    <= '0;
    end else if (step.valid) begin
      scan_bytes_r <= scan_bytes_nxt;
      scan_items_r <= scan_items_nxt;
      held_bytes_r <= held_bytes_nxt;
      full_r       <= full_nxt;
      pending_r    <= pending_nxt;
    end
  end

  `BBCG_ASSERT(a_err_holds_level, step.valid && err |=> held_bytes_r == $past(held_bytes_r))
  `BBCG_ASSERT(a_wake_clears_full, step.valid && wake |=> !full_r && pending_r == '0)
  `BBCG_ASSERT(a_full_set_by_read, $rose(full_r) |-> $past(step.valid && step.command == CMD_READ))
  `BBCG_ASSERT(a_accept_counts, step.valid && acc |=> scan_items_r == $past(scan_items_r) + 1'b1)
  `BBCG_ASSERT_RST(a_reset_clears, !rst_n |=> !full_r && held_bytes_r == '0)

endmodule
